// File: sv/depth_neighbour_count_denoise_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the depth neighbour count denoise unit
// Each macro expects clk and rst in scope of the module that uses it.
// ----------------------------------------------------------------------------
`ifndef DEPTH_NEIGHBOUR_COUNT_DENOISE_UNIT_ASSERT_SVH
`define DEPTH_NEIGHBOUR_COUNT_DENOISE_UNIT_ASSERT_SVH

// cons must hold in the same cycle as ante
`define DNC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define DNC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dnc_pkg.sv
// ----------------------------------------------------------------------------
// dnc_pkg
// Field widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package dnc_pkg;

  localparam int DEPTH_W    = 16;
  localparam int SIZE_W     = 11;
  localparam int THRESH_W   = 17;
  localparam int MINN_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int MIN_SIZE   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_NEIGHBOURS = 2'd3;

  localparam logic [SIZE_W-1:0]   RST_IMAGE_WIDTH    = 11'd640;
  localparam logic [SIZE_W-1:0]   RST_IMAGE_HEIGHT   = 11'd480;
  localparam logic [THRESH_W-1:0] RST_DIFF_THRESHOLD = 17'd64;
  localparam logic [MINN_W-1:0]   RST_MIN_NEIGHBOURS = 5'd4;

  typedef struct packed {
    logic [THRESH_W-1:0] diff_threshold;
    logic [MINN_W-1:0]   min_neighbours;
  } filter_cfg_t;

endpackage

// File: sv/dnc_ram.sv
// ----------------------------------------------------------------------------
// dnc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dnc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/dnc_count.sv
// ----------------------------------------------------------------------------
// dnc_count
// Counts similar neighbours in the clipped window and decides pass or drop.
// ----------------------------------------------------------------------------
module dnc_count #(
  parameter int WINDOW_RADIUS = 2
) (
  // window[k][j]: column slot k (0 = rightmost), row slot j (0 = bottom)
  input  logic [2*WINDOW_RADIUS:0][2*WINDOW_RADIUS:0][dnc_pkg::DEPTH_W-1:0] window,
  input  logic [2*WINDOW_RADIUS:0] row_valid,
  input  logic [2*WINDOW_RADIUS:0] col_valid,
  input  dnc_pkg::filter_cfg_t     cfg,
  output logic                     pass
);

  localparam int N     = 2 * WINDOW_RADIUS + 1;
  localparam int CNT_W = $clog2(N * N);

  logic [dnc_pkg::DEPTH_W-1:0] centre;
  logic [dnc_pkg::DEPTH_W-1:0] diff [N][N];
  logic [N-1:0][N-1:0]         similar;
  logic [CNT_W-1:0]            count;

  assign centre = window[WINDOW_RADIUS][WINDOW_RADIUS];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      for (int j = 0; j < N; j++) begin
        diff[k][j] = (centre > window[k][j]) ? centre - window[k][j]
                                             : window[k][j] - centre;
        similar[k][j] = col_valid[k] && row_valid[j] &&
                        !(k == WINDOW_RADIUS && j == WINDOW_RADIUS) &&
                        ({1'b0, diff[k][j]} < cfg.diff_threshold);
      end
    end
  end

  always_comb begin
    count = '0;
    for (int k = 0; k < N; k++) begin
      for (int j = 0; j < N; j++) begin
        count = count + CNT_W'(similar[k][j]);
      end
    end
  end

  assign pass = int'(count) >= int'(cfg.min_neighbours);

endmodule

// File: sv/depth_neighbour_count_denoise_unit.sv
// ----------------------------------------------------------------------------
// depth_neighbour_count_denoise_unit
// Neighbour count outlier filter over a clipped square window of depth pixels.
// ----------------------------------------------------------------------------
// Takes one transaction per clock and gives one result per clock once the
// window is full and while the result stream is not stalled: a pixel enters,
// its column is read from the line buffer RAM (one read and one write per
// cycle, column address), and the count and the pass decision settle between
// the input stage and the output register. A result belongs to the centre
// WINDOW_RADIUS rows plus WINDOW_RADIUS pixels behind the input; drain
// transactions after the frame's last pixel flush the remaining results, and a
// drain while pixels are still expected is dropped. The line buffer needs no
// clearing: rows outside the frame are masked.
// ----------------------------------------------------------------------------
`include "depth_neighbour_count_denoise_unit_assert.svh"

module depth_neighbour_count_denoise_unit #(
  parameter int MAX_WIDTH     = 1024,
  parameter int MAX_HEIGHT    = 1024,
  parameter int WINDOW_RADIUS = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [dnc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dnc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [dnc_pkg::DEPTH_W-1:0]       s_axis_tdata,  // [15:0] depth_in
  input  logic                              s_axis_tuser,  // [0] req_type
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [dnc_pkg::DEPTH_W-1:0]       m_axis_tdata,  // [15:0] depth_out
  output logic                              m_axis_tlast   // last_of_frame
);

  localparam int N       = 2 * WINDOW_RADIUS + 1;
  localparam int LB_ROWS = 2 * WINDOW_RADIUS;
  localparam int LB_W    = LB_ROWS * dnc_pkg::DEPTH_W;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int CROW_W  = $clog2(MAX_HEIGHT);
  localparam int ROW_W   = $clog2(MAX_HEIGHT + WINDOW_RADIUS + 1);
  localparam int WV_W    = $clog2(MAX_WIDTH + 1);
  localparam int HV_W    = $clog2(MAX_HEIGHT + 1);

  // configuration registers
  logic [dnc_pkg::SIZE_W-1:0]   image_width;
  logic [dnc_pkg::SIZE_W-1:0]   image_height;
  logic [dnc_pkg::THRESH_W-1:0] diff_threshold;
  logic [dnc_pkg::MINN_W-1:0]   min_neighbours;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= dnc_pkg::RST_IMAGE_WIDTH;
      image_height   <= dnc_pkg::RST_IMAGE_HEIGHT;
      diff_threshold <= dnc_pkg::RST_DIFF_THRESHOLD;
      min_neighbours <= dnc_pkg::RST_MIN_NEIGHBOURS;
    end else if (cfg_we) begin
      case (cfg_index)
        dnc_pkg::REG_IMAGE_WIDTH: begin
          image_width <= cfg_data[dnc_pkg::SIZE_W-1:0];
        end
        dnc_pkg::REG_IMAGE_HEIGHT: begin
          image_height <= cfg_data[dnc_pkg::SIZE_W-1:0];
        end
        dnc_pkg::REG_DIFF_THRESHOLD: begin
          diff_threshold <= cfg_data[dnc_pkg::THRESH_W-1:0];
        end
        dnc_pkg::REG_MIN_NEIGHBOURS: begin
          min_neighbours <= cfg_data[dnc_pkg::MINN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // saturated frame size
  logic [WV_W-1:0] w_eff;
  logic [HV_W-1:0] h_eff;

  always_comb begin
    if (int'(image_width) < dnc_pkg::MIN_SIZE) begin
      w_eff = WV_W'(dnc_pkg::MIN_SIZE);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w_eff = WV_W'(MAX_WIDTH);
    end else begin
      w_eff = WV_W'(image_width);
    end
    if (int'(image_height) < dnc_pkg::MIN_SIZE) begin
      h_eff = HV_W'(dnc_pkg::MIN_SIZE);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      h_eff = HV_W'(MAX_HEIGHT);
    end else begin
      h_eff = HV_W'(image_height);
    end
  end

  // frame positions
  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  cen_col;
  logic [CROW_W-1:0] cen_row;

  logic         accept;
  logic         pixel_phase;
  logic         in_keep;
  logic         in_write;
  logic         in_emit;
  logic         in_last;
  logic         in_col_wrap;
  logic         cen_col_wrap;
  logic [N-1:0] in_row_valid;
  logic [N-1:0] in_col_valid;

  assign accept       = s_axis_tvalid && s_axis_tready;
  assign pixel_phase  = int'(in_row) < int'(h_eff);
  assign in_keep      = accept && !(s_axis_tuser && pixel_phase);
  assign in_write     = !s_axis_tuser && pixel_phase;
  assign in_emit      = !(int'(in_row) < WINDOW_RADIUS ||
                          (int'(in_row) == WINDOW_RADIUS &&
                           int'(in_col) < WINDOW_RADIUS));
  assign in_col_wrap  = int'(in_col) + 1 >= int'(w_eff);
  assign cen_col_wrap = int'(cen_col) + 1 >= int'(w_eff);
  assign in_last      = in_emit && cen_col_wrap && (int'(cen_row) + 1 >= int'(h_eff));

  // clip the window at the frame edges around the current centre
  always_comb begin
    for (int j = 0; j < N; j++) begin
      in_row_valid[j] = (int'(cen_row) + WINDOW_RADIUS >= j) &&
                        (int'(cen_row) + WINDOW_RADIUS + 1 <= int'(h_eff) + j);
    end
    for (int k = 0; k < N; k++) begin
      in_col_valid[k] = (int'(cen_col) + WINDOW_RADIUS >= k) &&
                        (int'(cen_col) + WINDOW_RADIUS + 1 <= int'(w_eff) + k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      cen_col <= '0;
      cen_row <= '0;
    end else if (in_keep) begin
      if (in_last) begin
        in_col  <= '0;
        in_row  <= '0;
        cen_col <= '0;
        cen_row <= '0;
      end else begin
        if (in_col_wrap) begin
          in_col <= '0;
          in_row <= in_row + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
        if (in_emit) begin
          if (cen_col_wrap) begin
            cen_col <= '0;
            cen_row <= cen_row + 1'b1;
          end else begin
            cen_col <= cen_col + 1'b1;
          end
        end
      end
    end
  end

  // input stage
  logic                        s1_valid;
  logic                        s1_adv;
  logic [dnc_pkg::DEPTH_W-1:0] s1_pixel;
  logic [COL_W-1:0]            s1_col;
  logic                        s1_emit;
  logic                        s1_last;
  logic [N-1:0]                s1_row_valid;
  logic [N-1:0]                s1_col_valid;

  assign s1_adv        = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= in_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_keep) begin
      s1_pixel     <= in_write ? s_axis_tdata : '0;
      s1_col       <= in_col;
      s1_emit      <= in_emit;
      s1_last      <= in_last;
      s1_row_valid <= in_row_valid;
      s1_col_valid <= in_col_valid;
    end
  end

  // line buffer: one word per column holds the previous rows, newest lowest
  logic [LB_W-1:0] ram_rdata;
  logic [LB_W-1:0] ram_wdata;

  dnc_ram #(
    .WIDTH (LB_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (ram_wdata),
    .re    (in_keep),
    .raddr (in_col),
    .rdata (ram_rdata)
  );

  // window columns; slot 0 is formed from the RAM word and the new pixel
  logic [N-1:0][dnc_pkg::DEPTH_W-1:0]          new_col;
  logic [N-1:1][N-1:0][dnc_pkg::DEPTH_W-1:0]   win_cols;
  logic [N-1:0][N-1:0][dnc_pkg::DEPTH_W-1:0]   cur_win;

  always_comb begin
    new_col[0] = s1_pixel;
    for (int j = 1; j < N; j++) begin
      new_col[j] = ram_rdata[(j-1)*dnc_pkg::DEPTH_W +: dnc_pkg::DEPTH_W];
    end
    for (int j = 0; j < LB_ROWS; j++) begin
      ram_wdata[j*dnc_pkg::DEPTH_W +: dnc_pkg::DEPTH_W] = new_col[j];
    end
    cur_win[0] = new_col;
    for (int k = 1; k < N; k++) begin
      cur_win[k] = win_cols[k];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win_cols[1] <= new_col;
      for (int k = 2; k < N; k++) begin
        win_cols[k] <= win_cols[k-1];
      end
    end
  end

  dnc_pkg::filter_cfg_t filter_cfg;
  logic                 pass;

  assign filter_cfg.diff_threshold = diff_threshold;
  assign filter_cfg.min_neighbours = min_neighbours;

  dnc_count #(
    .WINDOW_RADIUS (WINDOW_RADIUS)
  ) u_count (
    .window    (cur_win),
    .row_valid (s1_row_valid),
    .col_valid (s1_col_valid),
    .cfg       (filter_cfg),
    .pass      (pass)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_axis_tvalid <= s1_emit;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_axis_tdata <= pass ? cur_win[WINDOW_RADIUS][WINDOW_RADIUS] : '0;
      m_axis_tlast <= s1_last;
    end
  end

  // within a frame consecutive columns differ, so the RAM ports never meet
  `DNC_ASSERT_SAME(a_ram_no_collision, s1_adv && in_keep && !s1_last,
                   s1_col != in_col, "line buffer read and write hit one column")
  // ready drops only while both the input stage and the result register are full
  `DNC_ASSERT_SAME(a_ready_only_when_full, !s_axis_tready,
                   s1_valid && m_axis_tvalid, "input stalled with a free stage")
  // the frame's last transaction returns every position to the origin
  `DNC_ASSERT_NEXT(a_frame_restart, in_keep && in_last,
                   in_col == '0 && in_row == '0 && cen_col == '0 && cen_row == '0,
                   "positions not cleared after frame end")

endmodule

// File: tb/sv/depth_denoise_checker.sv
// ----------------------------------------------------------------------------
// depth_denoise_checker
// Watches the register port and both streams of the depth denoise unit,
// predicts each filtered pixel from its own copy of the line store, window
// counters and registers, and compares every result transaction in order.
// ----------------------------------------------------------------------------
module depth_denoise_checker
  import dnc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [DEPTH_W-1:0]    in_data,   // [15:0] depth_in
  input  logic                  in_user,   // [0] req_type
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [DEPTH_W-1:0]    out_data,  // [15:0] depth_out
  input  logic                  out_last,  // last_of_frame
  output int                    mismatches,
  output int                    outstanding
);

  localparam int MAX_W      = 1024;
  localparam int MAX_H      = 1024;
  localparam int RADIUS     = 2;
  localparam int STORE_ROWS = 2 * RADIUS + 2;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               frame_end;
  } denoise_result_t;

  logic [DEPTH_W-1:0]  depth_rows [STORE_ROWS*MAX_W];
  logic [SIZE_W-1:0]   width_reg;
  logic [SIZE_W-1:0]   height_reg;
  logic [THRESH_W-1:0] thresh_reg;
  logic [MINN_W-1:0]   min_reg;
  int                  in_col;
  int                  in_row;
  int                  ctr_col;
  int                  ctr_row;
  int                  results_seen;
  denoise_result_t     filtered_q [$];
  denoise_result_t     predicted;
  denoise_result_t     oldest;

  function automatic int clip_size(int v, int hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  // Count similar pixels in the clipped window, centre excluded; return the centre depth if enough, else zero.
  function automatic logic [DEPTH_W-1:0] vote_centre(int cr, int cc, int w, int h);
    int ylo, yhi, xlo, xhi, y, x, votes, centre, nb, abs_gap;
    centre = depth_rows[(cr % STORE_ROWS) * MAX_W + cc];
    ylo = (cr >= RADIUS) ? cr - RADIUS : 0;
    yhi = (cr + RADIUS <= h - 1) ? cr + RADIUS : h - 1;
    xlo = (cc >= RADIUS) ? cc - RADIUS : 0;
    xhi = (cc + RADIUS <= w - 1) ? cc + RADIUS : w - 1;
    votes = 0;
    for (y = ylo; y <= yhi; y++) begin
      for (x = xlo; x <= xhi; x++) begin
        if (y == cr && x == cc) continue;
        nb = depth_rows[(y % STORE_ROWS) * MAX_W + x];
        abs_gap = (centre > nb) ? centre - nb : nb - centre;
        if (abs_gap < int'(thresh_reg)) votes++;
      end
    end
    return (votes >= int'(min_reg)) ? DEPTH_W'(centre) : '0;
  endfunction

  // Advance the frame position for one transaction; returns 1 when a
  // filtered pixel falls due.
  function automatic bit denoise_step(input logic drain, input logic [DEPTH_W-1:0] d,
                                      output denoise_result_t r);
    int  w, h, pos, lag;
    bit  pixel_phase;
    w = clip_size(int'(width_reg), MAX_W);
    h = clip_size(int'(height_reg), MAX_H);
    pixel_phase = in_row < h;
    r = '0;
    // drop a drain while the frame still expects pixels
    if (drain && pixel_phase) return 0;
    if (!drain && pixel_phase) depth_rows[(in_row % STORE_ROWS) * MAX_W + in_col] = d;
    pos = in_row * w + in_col;
    lag = RADIUS * w + RADIUS;
    if (in_col >= w - 1) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col++;
    end
    if (pos < lag) return 0;
    r.depth = vote_centre(ctr_row, ctr_col, w, h);
    r.frame_end = (ctr_row >= h - 1) && (ctr_col >= w - 1);
    if (r.frame_end) begin
      in_col = 0;
      in_row = 0;
      ctr_col = 0;
      ctr_row = 0;
    end else if (ctr_col >= w - 1) begin
      ctr_col = 0;
      ctr_row++;
    end else begin
      ctr_col++;
    end
    return 1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_reg = RST_IMAGE_WIDTH;
      height_reg = RST_IMAGE_HEIGHT;
      thresh_reg = RST_DIFF_THRESHOLD;
      min_reg = RST_MIN_NEIGHBOURS;
      in_col = 0;
      in_row = 0;
      ctr_col = 0;
      ctr_row = 0;
      results_seen = 0;
      mismatches = 0;
      filtered_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:    width_reg = cfg_data[SIZE_W-1:0];
          REG_IMAGE_HEIGHT:   height_reg = cfg_data[SIZE_W-1:0];
          REG_DIFF_THRESHOLD: thresh_reg = cfg_data[THRESH_W-1:0];
          REG_MIN_NEIGHBOURS: min_reg = cfg_data[MINN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (denoise_step(in_user, in_data, predicted)) filtered_q.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: unexpected transaction, depth %h last %b",
                     results_seen, out_data, out_last);
        end else begin
          oldest = filtered_q.pop_front();
          if (out_data !== oldest.depth || out_last !== oldest.frame_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected depth %h last %b, got depth %h last %b",
                       results_seen, oldest.depth, oldest.frame_end, out_data, out_last);
          end
        end
        results_seen++;
      end
    end
    outstanding <= filtered_q.size();
  end

endmodule

// File: tb/sv/tb_depth_neighbour_count_denoise_unit.sv
// ----------------------------------------------------------------------------
// tb_depth_neighbour_count_denoise_unit
// Streams depth frames of many sizes, thresholds and neighbour minimums
// through the denoise unit with random stalls on both sides; a checker
// beside the block predicts and compares every filtered pixel.
// ----------------------------------------------------------------------------
module tb_depth_neighbour_count_denoise_unit;
  import dnc_pkg::*;

  localparam int MAX_W        = 1024;
  localparam int MAX_H        = 1024;
  localparam int TARGET_ITEMS = 900;
  localparam int SETTLE_CYC   = 16;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [DEPTH_W-1:0]    s_data = '0;
  logic                  s_user = 1'b0;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [DEPTH_W-1:0]    m_data;
  logic                  m_last;
  int                    mismatch_count;
  int                    pending_results;

  int cur_w;
  int cur_h;
  int items_done;
  bit steady;

  depth_neighbour_count_denoise_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),   // [15:0] depth_in
    .s_axis_tuser (s_user),   // [0] req_type
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),   // [15:0] depth_out
    .m_axis_tlast (m_last)    // last_of_frame
  );

  depth_denoise_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_valid),
    .in_ready   (s_ready),
    .in_data    (s_data),
    .in_user    (s_user),
    .out_valid  (m_valid),
    .out_ready  (m_ready),
    .out_data   (m_data),
    .out_last   (m_last),
    .mismatches (mismatch_count),
    .outstanding(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("depth_neighbour_count_denoise_unit test failed");
    $finish;
  end

  function automatic int clip_size(int v, int hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: ready bursts, long calm stretches now and then
  initial begin
    int burst, gap;
    forever begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      m_ready <= 1'b1;
      repeat (burst) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic drain, input logic [DEPTH_W-1:0] d);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data <= d;
    s_user <= drain;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    items_done++;
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
  endtask

  task automatic set_config(input int w, input int h, input int thr, input int mn);
    put_reg(REG_IMAGE_WIDTH, w);
    put_reg(REG_IMAGE_HEIGHT, h);
    put_reg(REG_DIFF_THRESHOLD, thr);
    put_reg(REG_MIN_NEIGHBOURS, mn);
    cfg_we <= 1'b0;
    cur_w = clip_size(w, MAX_W);
    cur_h = clip_size(h, MAX_H);
  endtask

  // hold input, wait for every result, then let the pipeline empty
  task automatic settle();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic logic [DEPTH_W-1:0] make_depth(int mode, int base, int noise);
    int v;
    case (mode)
      0: v = $urandom_range(0, 65535);
      1: begin
        if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 65535);
        else v = base + $urandom_range(0, 2 * noise) - noise;
      end
      default: v = ($urandom_range(0, 3) == 0) ? 0 : base;
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return DEPTH_W'(v);
  endfunction

  // one frame: pixels with stray drains, then the flush with drains and
  // pixels that stand in for drains
  task automatic run_frame();
    int mode, base, noise, i, lag;
    mode = $urandom_range(0, 2);
    case ($urandom_range(0, 3))
      0: base = 0;
      1: base = 65535;
      default: base = $urandom_range(0, 65535);
    endcase
    noise = $urandom_range(0, 300);
    lag = 2 * cur_w + 2;
    steady = ($urandom_range(0, 3) == 0);
    for (i = 0; i < cur_w * cur_h; i++) begin
      if ($urandom_range(0, 11) == 0) send_item(1'b1, DEPTH_W'($urandom_range(0, 65535)));
      send_item(1'b0, make_depth(mode, base, noise));
    end
    for (i = 0; i < lag; i++) begin
      if ($urandom_range(0, 3) == 0) send_item(1'b0, DEPTH_W'($urandom_range(0, 65535)));
      else send_item(1'b1, DEPTH_W'($urandom_range(0, 65535)));
    end
  endtask

  function automatic int pick_size(int hi);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, MIN_SIZE - 1);
    return $urandom_range(MIN_SIZE, hi);
  endfunction

  function automatic int pick_thresh();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return 65535;
      3: return 65536;
      4: return 131071;
      5: return $urandom_range(0, 131071);
      default: return $urandom_range(2, 400);
    endcase
  endfunction

  function automatic int pick_min();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 24;
      2: return 25;
      3: return 31;
      default: return $urandom_range(1, 10);
    endcase
  endfunction

  initial begin
    int  frame_no;
    items_done = 0;
    steady = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 3x3 frame: threshold 1 counts only equal depths, four needed to survive;
    // drains during pixels are dropped, pixels during flush act as drains
    set_config(3, 3, 1, 4);
    send_item(1'b1, 16'hFFFF);
    send_item(1'b0, 16'hFFFF);
    send_item(1'b0, 16'h0001);
    send_item(1'b0, 16'hFFFF);
    send_item(1'b0, 16'h0002);
    send_item(1'b1, 16'h0000);
    send_item(1'b0, 16'hFFFF);
    send_item(1'b0, 16'h0000);
    send_item(1'b0, 16'hFFFF);
    send_item(1'b0, 16'h0003);
    send_item(1'b0, 16'hFFFF);
    send_item(1'b1, 16'h0000);
    send_item(1'b0, 16'hA5A5);
    send_item(1'b1, 16'h5A5A);
    send_item(1'b1, 16'hFFFF);
    send_item(1'b0, 16'h0000);
    send_item(1'b1, 16'h0000);
    send_item(1'b1, 16'h1234);
    send_item(1'b1, 16'h0000);

    frame_no = 0;
    while (items_done < TARGET_ITEMS) begin
      if (frame_no == 0 || $urandom_range(0, 9) < 7) begin
        settle();
        set_config(pick_size(12), pick_size(8), pick_thresh(), pick_min());
      end
      run_frame();
      frame_no++;
    end

    settle();
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("depth_neighbour_count_denoise_unit test passed");
    end else begin
      $display("depth_neighbour_count_denoise_unit test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/dnc_pkg.sv
sv/dnc_ram.sv
sv/dnc_count.sv
sv/depth_neighbour_count_denoise_unit.sv
tb/sv/depth_denoise_checker.sv
tb/sv/tb_depth_neighbour_count_denoise_unit.sv
